FILE: sv/t_junction_signal_sequencer_macros.svh
`ifndef T_JUNCTION_SIGNAL_SEQUENCER_MACROS_SVH
`define T_JUNCTION_SIGNAL_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TJSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tjss check failed");

// next-cycle implication, checked outside reset
`define TJSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tjss check failed");

`endif

FILE: sv/tjss_pkg.sv
package tjss_pkg;

    localparam int TICK_W  = 13;
    localparam int GREEN_W = 11;
    localparam int SUM_W   = 14;
    localparam int COUNT_W = 8;
    localparam int DATA_W  = 10;

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_GREEN  = 2'd1,
        LAMP_YELLOW = 2'd2
    } lamp_t;

    // lamp order: east through, west through, east left, south left
    typedef lamp_t [3:0] lamps_t;

    typedef enum logic [1:0] {
        PHASE_THROUGH    = 2'd0,
        PHASE_EAST_LEFT  = 2'd1,
        PHASE_SOUTH_LEFT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_GREEN_TIME      = 3'd0,
        REG_YELLOW_TIME     = 3'd1,
        REG_GREEN_REDUCTION = 3'd2,
        REG_GREEN_EXTENSION = 3'd3,
        REG_LIGHT_LEVEL     = 3'd4,
        REG_NORMAL_LEVEL    = 3'd5,
        REG_HEAVY_LEVEL     = 3'd6,
        REG_ADAPTIVE_MODE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [9:0] green_time;
        logic [7:0] yellow_time;
        logic [7:0] green_reduction;
        logic [7:0] green_extension;
        logic [7:0] light_level;
        logic [7:0] normal_level;
        logic [7:0] heavy_level;
        logic       adaptive_mode;
    } cfg_t;

    typedef struct packed {
        logic               restart;
        logic [COUNT_W-1:0] east_through_count;
        logic [COUNT_W-1:0] west_through_count;
        logic [COUNT_W-1:0] east_left_count;
        logic [COUNT_W-1:0] south_left_count;
    } tick_item_t;

    localparam logic [9:0] RST_GREEN_TIME      = 10'd30;
    localparam logic [7:0] RST_YELLOW_TIME     = 8'd3;
    localparam logic [7:0] RST_GREEN_REDUCTION = 8'd10;
    localparam logic [7:0] RST_GREEN_EXTENSION = 8'd10;
    localparam logic [7:0] RST_LIGHT_LEVEL     = 8'd5;
    localparam logic [7:0] RST_NORMAL_LEVEL    = 8'd10;
    localparam logic [7:0] RST_HEAVY_LEVEL     = 8'd20;

    function automatic lamps_t show_phase(phase_t phase, lamp_t color);
        lamps_t l;
        l = '{4{LAMP_RED}};
        case (phase)
            PHASE_THROUGH:
            begin
                l[0] = color;
                l[1] = color;
            end
            PHASE_EAST_LEFT:  l[2] = color;
            default:          l[3] = color;
        endcase
        return l;
    endfunction

    // counts above the normal level, heavy or not, land in the heavy band
    function automatic logic [GREEN_W-1:0] green_for(cfg_t cfg, logic [COUNT_W-1:0] count);
        logic [GREEN_W-1:0] g;
        if (count == '0)
            g = '0;
        else if (count <= cfg.light_level)
            g = (cfg.green_time > {2'b00, cfg.green_reduction}) ?
                ({1'b0, cfg.green_time} - {3'b000, cfg.green_reduction}) : '0;
        else if (count <= cfg.normal_level)
            g = {1'b0, cfg.green_time};
        else
            g = {1'b0, cfg.green_time} + {3'b000, cfg.green_extension};
        return g;
    endfunction

endpackage

FILE: sv/tjss_cfg.sv
module tjss_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [2:0]                  cfg_index,
    input  logic [tjss_pkg::DATA_W-1:0] cfg_data,
    output tjss_pkg::cfg_t              cfg
);

    tjss_pkg::cfg_t cfg_reg;
    tjss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (tjss_pkg::reg_idx_t'(cfg_index))
                tjss_pkg::REG_GREEN_TIME:      cfg_next.green_time      = cfg_data;
                tjss_pkg::REG_YELLOW_TIME:     cfg_next.yellow_time     = cfg_data[7:0];
                tjss_pkg::REG_GREEN_REDUCTION: cfg_next.green_reduction = cfg_data[7:0];
                tjss_pkg::REG_GREEN_EXTENSION: cfg_next.green_extension = cfg_data[7:0];
                tjss_pkg::REG_LIGHT_LEVEL:     cfg_next.light_level     = cfg_data[7:0];
                tjss_pkg::REG_NORMAL_LEVEL:    cfg_next.normal_level    = cfg_data[7:0];
                tjss_pkg::REG_HEAVY_LEVEL:     cfg_next.heavy_level     = cfg_data[7:0];
                tjss_pkg::REG_ADAPTIVE_MODE:   cfg_next.adaptive_mode   = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_time      <= tjss_pkg::RST_GREEN_TIME;
            cfg_reg.yellow_time     <= tjss_pkg::RST_YELLOW_TIME;
            cfg_reg.green_reduction <= tjss_pkg::RST_GREEN_REDUCTION;
            cfg_reg.green_extension <= tjss_pkg::RST_GREEN_EXTENSION;
            cfg_reg.light_level     <= tjss_pkg::RST_LIGHT_LEVEL;
            cfg_reg.normal_level    <= tjss_pkg::RST_NORMAL_LEVEL;
            cfg_reg.heavy_level     <= tjss_pkg::RST_HEAVY_LEVEL;
            cfg_reg.adaptive_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/tjss_core.sv
module tjss_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tjss_pkg::cfg_t         cfg,
    input  logic                   step,
    input  tjss_pkg::tick_item_t   item,
    output tjss_pkg::lamps_t       lamps
);

    localparam int TW = tjss_pkg::TICK_W;
    localparam int GW = tjss_pkg::GREEN_W;
    localparam int SW = tjss_pkg::SUM_W;

    logic [TW-1:0]          tick_reg;
    logic [TW-1:0]          tick_next;
    logic [2:0][GW-1:0]     green_reg;
    logic [2:0][GW-1:0]     green_next;
    tjss_pkg::lamps_t       lamps_reg;
    tjss_pkg::lamps_t       lamps_next;

    logic [TW-1:0]          t;
    logic                   first;
    logic                   advance;
    logic [tjss_pkg::COUNT_W-1:0] through_max;
    logic [2:0][GW-1:0]     green_new;
    logic [GW-1:0]          g0;
    logic [GW-1:0]          g1;
    logic [GW-1:0]          g2;
    logic [SW-1:0]          y;
    logic [SW-1:0]          tt;
    logic [SW-1:0]          end_g0;
    logic [SW-1:0]          end_y0;
    logic [SW-1:0]          end_g1;
    logic [SW-1:0]          end_y1;
    logic [SW-1:0]          end_g2;
    logic [SW-1:0]          end_y2;
    tjss_pkg::lamps_t       lamps_calc;
    logic [TW-1:0]          tick_calc;

    always_comb
    begin
        t       = tick_reg + TW'(1);
        first   = (t == TW'(1));
        advance = !(item.restart && !cfg.adaptive_mode);

        through_max = (item.east_through_count > item.west_through_count) ?
                      item.east_through_count : item.west_through_count;
        if (cfg.adaptive_mode)
        begin
            green_new[0] = tjss_pkg::green_for(cfg, through_max);
            green_new[1] = tjss_pkg::green_for(cfg, item.east_left_count);
            green_new[2] = tjss_pkg::green_for(cfg, item.south_left_count);
        end
        else
        begin
            green_new[0] = GW'(cfg.green_time);
            green_new[1] = GW'(cfg.green_time);
            green_new[2] = GW'(cfg.green_time);
        end

        g0 = first ? green_new[0] : green_reg[0];
        g1 = first ? green_new[1] : green_reg[1];
        g2 = first ? green_new[2] : green_reg[2];

        // phase boundaries within one signal sequence
        y      = SW'(cfg.yellow_time);
        tt     = SW'(t);
        end_g0 = SW'(g0);
        end_y0 = end_g0 + y;
        end_g1 = end_y0 + SW'(g1);
        end_y1 = end_g1 + y;
        end_g2 = end_y1 + SW'(g2);
        end_y2 = end_g2 + y;

        lamps_calc = lamps_reg;
        if (first)
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_THROUGH, tjss_pkg::LAMP_GREEN);
        if (tt == end_g0 || (g0 == '0 && first))
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_THROUGH, tjss_pkg::LAMP_YELLOW);
        if (tt == end_y0)
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_EAST_LEFT, tjss_pkg::LAMP_GREEN);
        if (tt == end_g1)
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_EAST_LEFT, tjss_pkg::LAMP_YELLOW);
        if (tt == end_y1)
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_SOUTH_LEFT, tjss_pkg::LAMP_GREEN);
        if (tt == end_g2)
            lamps_calc = tjss_pkg::show_phase(tjss_pkg::PHASE_SOUTH_LEFT, tjss_pkg::LAMP_YELLOW);
        tick_calc = (tt >= end_y2) ? '0 : t;

        tick_next  = tick_reg;
        green_next = green_reg;
        lamps_next = lamps_reg;
        if (step)
        begin
            if (advance)
            begin
                tick_next  = tick_calc;
                lamps_next = lamps_calc;
                if (first)
                    green_next = green_new;
            end
            if (item.restart)
                tick_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            green_reg <= {3{GW'(tjss_pkg::RST_GREEN_TIME)}};
            lamps_reg <= '{4{tjss_pkg::LAMP_RED}};
        end
        else
        begin
            tick_reg  <= tick_next;
            green_reg <= green_next;
            lamps_reg <= lamps_next;
        end
    end

    assign lamps = lamps_reg;

endmodule

FILE: sv/t_junction_signal_sequencer.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     restart, four queue counts
// out       output     out_valid / out_stall   four lamp colors
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one tick item per cycle unless out stalls; each item passes both stages to the output once it is taken
// stage one is the input register, stage two the lamp state, which is also the result register
// the tick counter and lamp state feed back only into themselves, so items go back to back
// rst_n clears all config to its default, the counter to zero and every lamp to red
// a stalled output holds the lamps; input stalls only when both stages are full and out is stalled
module t_junction_signal_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart,
    input  logic [7:0]                  east_through_count,
    input  logic [7:0]                  west_through_count,
    input  logic [7:0]                  east_left_count,
    input  logic [7:0]                  south_left_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  east_through_lamp,
    output logic [1:0]                  west_through_lamp,
    output logic [1:0]                  east_left_lamp,
    output logic [1:0]                  south_left_lamp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [tjss_pkg::DATA_W-1:0] cfg_data
);

    tjss_pkg::cfg_t       cfg;
    tjss_pkg::tick_item_t item_reg;
    tjss_pkg::lamps_t     lamps;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 step;

    assign cfg_ready = 1'b1;

    tjss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.restart            <= restart;
            item_reg.east_through_count <= east_through_count;
            item_reg.west_through_count <= west_through_count;
            item_reg.east_left_count    <= east_left_count;
            item_reg.south_left_count   <= south_left_count;
        end
    end

    tjss_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (item_reg),
        .lamps (lamps)
    );

    assign out_valid         = out_valid_reg;
    assign east_through_lamp = lamps[0];
    assign west_through_lamp = lamps[1];
    assign east_left_lamp    = lamps[2];
    assign south_left_lamp   = lamps[3];

endmodule

FILE: sv/tjss_checker.sv
`include "t_junction_signal_sequencer_macros.svh"

module tjss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] east_through_lamp,
    input logic [1:0] west_through_lamp,
    input logic [1:0] east_left_lamp,
    input logic [1:0] south_left_lamp
);

    // both through lamps show the same color whenever out is valid
    `TJSS_ASSERT_NOW(a_through_pair, clk, rst_n, out_valid, east_through_lamp == west_through_lamp)

    // an east left lamp that is lit means the east through and south left lamps are red
    `TJSS_ASSERT_NOW(a_east_left_alone, clk, rst_n, out_valid && east_left_lamp != tjss_pkg::LAMP_RED, east_through_lamp == tjss_pkg::LAMP_RED && south_left_lamp == tjss_pkg::LAMP_RED)

    // a south left lamp that is lit means the east through lamp is red
    `TJSS_ASSERT_NOW(a_south_left_alone, clk, rst_n, out_valid && south_left_lamp != tjss_pkg::LAMP_RED, east_through_lamp == tjss_pkg::LAMP_RED)

    // a stalled item stays on the port
    `TJSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(east_through_lamp) && $stable(east_left_lamp) && $stable(south_left_lamp))

endmodule

bind t_junction_signal_sequencer tjss_checker u_tjss_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .east_through_lamp (east_through_lamp),
    .west_through_lamp (west_through_lamp),
    .east_left_lamp    (east_left_lamp),
    .south_left_lamp   (south_left_lamp)
);
